/* rtl/assert_macros.svh */
// Assertion macros used by the checker file vrt_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled during an active-low reset.
`define VRT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the block clock and reset.
`define VRT_ASSERT(lbl, prop, msg) `VRT_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

/* rtl/vrt_pkg.sv */
// Types, codes and constants of the voxel ray traversal block.
// No dependencies.
package vrt_pkg;

    localparam int COORD_BITS_DEF      = 24;
    localparam int MAX_FREE_VOXELS_DEF = 63;

    localparam int SIZE_W     = 10;
    localparam int RANGE_W    = 20;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_ADDR_W-1:0] CFG_VOXEL_SIZE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RANGE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RANGE  = 2'd2;

    localparam logic [SIZE_W-1:0]  VOXEL_SIZE_RST = 10'd50;
    localparam logic [RANGE_W-1:0] MIN_RANGE_RST  = 20'd300;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST  = 20'd50000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_SUM,
        ST_CHECK,
        ST_DIVW,
        ST_PROD,
        ST_WALK,
        ST_FINAL
    } t_state;

    typedef enum logic [3:0] {
        MUL_SQ_X,
        MUL_SQ_Y,
        MUL_SQ_Z,
        MUL_MIN2,
        MUL_MAX2,
        MUL_SA_X,
        MUL_SA_Y,
        MUL_SA_Z,
        MUL_P_XY,
        MUL_P_YX,
        MUL_P_XZ,
        MUL_P_ZX,
        MUL_P_YZ,
        MUL_P_ZY
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        t_mul_op mul_op;
        logic    sum;
        logic    num_load;
        logic    step;
        logic    fin;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic in_range;
        logic at_end;
        logic k_full;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/vrt_div.sv */
// Bit-serial floor division of a signed coordinate by the voxel size.
// Depends on vrt_pkg.
module vrt_div #(
    parameter int COORD_BITS = vrt_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [COORD_BITS-1:0]     i_dividend,
    input  logic [vrt_pkg::SIZE_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [COORD_BITS-1:0]     o_quot,
    output logic [vrt_pkg::SIZE_W-1:0] o_rem
);
    import vrt_pkg::*;

    localparam int CNT_W = $clog2(COORD_BITS);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_neg;
    logic [SIZE_W-1:0]     r_s;
    logic [SIZE_W-1:0]     r_rem;
    logic [COORD_BITS-1:0] r_q;
    logic [SIZE_W:0]       trial;
    logic                  ge;

    assign trial = {r_rem, r_q[COORD_BITS-1]};
    assign ge    = trial >= {1'b0, r_s};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(COORD_BITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[COORD_BITS-1];
            r_s   <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend[COORD_BITS-1] ? (~i_dividend + 1'b1) : i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? SIZE_W'(trial - {1'b0, r_s}) : trial[SIZE_W-1:0];
            r_q   <= {r_q[COORD_BITS-2:0], ge};
        end
    end

    assign o_done = !r_busy;

    always_comb begin
        if (!r_neg) begin
            o_quot = r_q;
            o_rem  = r_rem;
        end else if (r_rem != '0) begin
            o_quot = ~r_q;
            o_rem  = r_s - r_rem;
        end else begin
            o_quot = ~r_q + 1'b1;
            o_rem  = '0;
        end
    end

endmodule

/* rtl/vrt_datapath.sv */
// Datapath: configuration registers, range check, divider lanes, shared
// multiplier, stepping products and the output register. Depends on vrt_pkg, vrt_div.
module vrt_datapath #(
    parameter int COORD_BITS      = vrt_pkg::COORD_BITS_DEF,
    parameter int MAX_FREE_VOXELS = vrt_pkg::MAX_FREE_VOXELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vrt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [vrt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [6*COORD_BITS-1:0]       i_coords,
    input  vrt_pkg::t_dp_cmd              i_cmd,
    output vrt_pkg::t_dp_stat             o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [3*COORD_BITS-1:0]       o_vox,
    output logic                          o_surf,
    output logic                          o_last,
    output logic                          o_cut
);
    import vrt_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int AW  = CW + 1;
    localparam int MW  = (AW > RANGE_W) ? AW : RANGE_W;
    localparam int KW  = $clog2(MAX_FREE_VOXELS + 1);
    localparam int PW  = SIZE_W + KW + AW;
    localparam int SAW = SIZE_W + AW;
    localparam int SQW = 2 * AW;
    localparam int M2W = 2 * RANGE_W;
    localparam int LW  = 2 * MW + 2;

    logic [SIZE_W-1:0]  r_size;
    logic [RANGE_W-1:0] r_min;
    logic [RANGE_W-1:0] r_max;
    logic [SIZE_W-1:0]  s_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= VOXEL_SIZE_RST;
            r_min  <= MIN_RANGE_RST;
            r_max  <= MAX_RANGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_VOXEL_SIZE: r_size <= i_cfg_data[SIZE_W-1:0];
                CFG_MIN_RANGE:  r_min  <= i_cfg_data[RANGE_W-1:0];
                CFG_MAX_RANGE:  r_max  <= i_cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_eff = (r_size == '0) ? SIZE_W'(1) : r_size;

    // ray deltas
    logic signed [AW-1:0] d_in [3];
    logic        [AW-1:0] ad_in [3];
    logic        [AW-1:0] r_ad [3];
    logic                 r_pos [3];
    logic                 nz [3];
    logic [SIZE_W-1:0]    r_s;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_in[i]  = $signed({i_coords[(i+3)*CW+CW-1], i_coords[(i+3)*CW +: CW]})
                     - $signed({i_coords[i*CW+CW-1], i_coords[i*CW +: CW]});
            ad_in[i] = d_in[i][AW-1] ? AW'(-d_in[i]) : AW'(d_in[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s <= s_eff;
            for (int i = 0; i < 3; i++) begin
                r_ad[i]  <= ad_in[i];
                r_pos[i] <= !d_in[i][AW-1] && (d_in[i] != '0);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nz[i] = r_ad[i] != '0;
        end
    end

    // divider lanes: origin x, y, z, then hit x, y, z
    logic [CW-1:0]     quot [6];
    logic [SIZE_W-1:0] rem  [6];
    logic [5:0]        done;

    for (genvar g = 0; g < 6; g++) begin : g_div
        vrt_div #(.COORD_BITS(CW)) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (i_cmd.load),
            .i_dividend (i_coords[g*CW +: CW]),
            .i_divisor  (s_eff),
            .o_done     (done[g]),
            .o_quot     (quot[g]),
            .o_rem      (rem[g])
        );
    end

    // shared multiplier
    logic [SIZE_W-1:0] r_num [3];
    logic [MW-1:0]     mul_a;
    logic [MW-1:0]     mul_b;
    logic [2*MW-1:0]   mul_p;

    always_comb begin
        case (i_cmd.mul_op)
            MUL_SQ_X: begin mul_a = MW'(r_ad[0]);    mul_b = MW'(r_ad[0]); end
            MUL_SQ_Y: begin mul_a = MW'(r_ad[1]);    mul_b = MW'(r_ad[1]); end
            MUL_SQ_Z: begin mul_a = MW'(r_ad[2]);    mul_b = MW'(r_ad[2]); end
            MUL_MIN2: begin mul_a = MW'(r_min);      mul_b = MW'(r_min);   end
            MUL_MAX2: begin mul_a = MW'(r_max);      mul_b = MW'(r_max);   end
            MUL_SA_X: begin mul_a = MW'(r_s);        mul_b = MW'(r_ad[0]); end
            MUL_SA_Y: begin mul_a = MW'(r_s);        mul_b = MW'(r_ad[1]); end
            MUL_SA_Z: begin mul_a = MW'(r_s);        mul_b = MW'(r_ad[2]); end
            MUL_P_XY: begin mul_a = MW'(r_num[0]);   mul_b = MW'(r_ad[1]); end
            MUL_P_YX: begin mul_a = MW'(r_num[1]);   mul_b = MW'(r_ad[0]); end
            MUL_P_XZ: begin mul_a = MW'(r_num[0]);   mul_b = MW'(r_ad[2]); end
            MUL_P_ZX: begin mul_a = MW'(r_num[2]);   mul_b = MW'(r_ad[0]); end
            MUL_P_YZ: begin mul_a = MW'(r_num[1]);   mul_b = MW'(r_ad[2]); end
            MUL_P_ZY: begin mul_a = MW'(r_num[2]);   mul_b = MW'(r_ad[1]); end
            default:  begin mul_a = '0;              mul_b = '0;           end
        endcase
        mul_p = mul_a * mul_b;
    end

    logic [SQW-1:0] r_sq [3];
    logic [M2W-1:0] r_min2;
    logic [M2W-1:0] r_max2;
    logic [SAW-1:0] r_sa [3];
    logic [LW-1:0]  r_len2;
    logic [PW-1:0]  r_pxy, r_pyx, r_pxz, r_pzx, r_pyz, r_pzy;

    // walk state
    logic signed [AW-1:0] r_cur [3];
    logic signed [AW-1:0] r_end [3];
    logic [KW-1:0]        r_k;
    logic                 x_lt_y, x_lt_z, y_lt_z;
    logic [1:0]           axis;
    logic                 at_end;

    assign x_lt_y = nz[0] && (!nz[1] || r_pxy < r_pyx);
    assign x_lt_z = nz[0] && (!nz[2] || r_pxz < r_pzx);
    assign y_lt_z = nz[1] && (!nz[2] || r_pyz < r_pzy);

    always_comb begin
        if (x_lt_y && x_lt_z) begin
            axis = 2'd0;
        end else if (y_lt_z) begin
            axis = 2'd1;
        end else begin
            axis = 2'd2;
        end
    end

    assign at_end = (r_cur[0] == r_end[0]) && (r_cur[1] == r_end[1])
                 && (r_cur[2] == r_end[2]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_op)
                MUL_SQ_X: r_sq[0] <= mul_p[SQW-1:0];
                MUL_SQ_Y: r_sq[1] <= mul_p[SQW-1:0];
                MUL_SQ_Z: r_sq[2] <= mul_p[SQW-1:0];
                MUL_MIN2: r_min2  <= mul_p[M2W-1:0];
                MUL_MAX2: r_max2  <= mul_p[M2W-1:0];
                MUL_SA_X: r_sa[0] <= mul_p[SAW-1:0];
                MUL_SA_Y: r_sa[1] <= mul_p[SAW-1:0];
                MUL_SA_Z: r_sa[2] <= mul_p[SAW-1:0];
                MUL_P_XY: r_pxy   <= mul_p[PW-1:0];
                MUL_P_YX: r_pyx   <= mul_p[PW-1:0];
                MUL_P_XZ: r_pxz   <= mul_p[PW-1:0];
                MUL_P_ZX: r_pzx   <= mul_p[PW-1:0];
                MUL_P_YZ: r_pyz   <= mul_p[PW-1:0];
                MUL_P_ZY: r_pzy   <= mul_p[PW-1:0];
                default: ;
            endcase
        end
        if (i_cmd.sum) begin
            r_len2 <= LW'(r_sq[0]) + LW'(r_sq[1]) + LW'(r_sq[2]);
        end
        if (i_cmd.num_load) begin
            r_k <= '0;
            for (int i = 0; i < 3; i++) begin
                r_cur[i] <= $signed({quot[i][CW-1], quot[i]});
                r_end[i] <= $signed({quot[i+3][CW-1], quot[i+3]});
                r_num[i] <= r_pos[i] ? (r_s - rem[i]) : rem[i];
            end
        end else if (i_cmd.step) begin
            r_k <= r_k + 1'b1;
            if (nz[axis]) begin
                r_cur[axis] <= r_pos[axis] ? r_cur[axis] + AW'(1) : r_cur[axis] - AW'(1);
                case (axis)
                    2'd0: begin
                        r_pxy <= r_pxy + PW'(r_sa[1]);
                        r_pxz <= r_pxz + PW'(r_sa[2]);
                    end
                    2'd1: begin
                        r_pyx <= r_pyx + PW'(r_sa[0]);
                        r_pyz <= r_pyz + PW'(r_sa[2]);
                    end
                    default: begin
                        r_pzx <= r_pzx + PW'(r_sa[0]);
                        r_pzy <= r_pzy + PW'(r_sa[1]);
                    end
                endcase
            end
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step || i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            o_vox  <= {r_cur[2][CW-1:0], r_cur[1][CW-1:0], r_cur[0][CW-1:0]};
            o_surf <= 1'b0;
            o_last <= 1'b0;
            o_cut  <= 1'b0;
        end else if (i_cmd.fin) begin
            o_vox  <= {r_end[2][CW-1:0], r_end[1][CW-1:0], r_end[0][CW-1:0]};
            o_surf <= 1'b1;
            o_last <= 1'b1;
            o_cut  <= !at_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.div_done = &done;
    assign o_stat.in_range = !((r_len2 < LW'(r_min2)) || (r_len2 > LW'(r_max2)));
    assign o_stat.at_end   = at_end;
    assign o_stat.k_full   = r_k >= KW'(MAX_FREE_VOXELS);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

/* rtl/vrt_ctrl.sv */
// Controller state machine sequencing setup, range check and the voxel walk.
// Depends on vrt_pkg.
module vrt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output vrt_pkg::t_dp_cmd  o_cmd,
    input  vrt_pkg::t_dp_stat i_stat
);
    import vrt_pkg::*;

    t_state  r_state, n_state;
    t_mul_op r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= MUL_SQ_X;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SQ;
                    n_op    = MUL_SQ_X;
                end
            end
            ST_SQ: begin
                if (r_op == MUL_SA_Z) begin
                    n_state = ST_SUM;
                end else begin
                    n_op = t_mul_op'(r_op + 4'd1);
                end
            end
            ST_SUM:   n_state = ST_CHECK;
            ST_CHECK: n_state = i_stat.in_range ? ST_DIVW : ST_IDLE;
            ST_DIVW: begin
                if (i_stat.div_done) begin
                    n_state = ST_PROD;
                    n_op    = MUL_P_XY;
                end
            end
            ST_PROD: begin
                if (r_op == MUL_P_ZY) begin
                    n_state = ST_WALK;
                end else begin
                    n_op = t_mul_op'(r_op + 4'd1);
                end
            end
            ST_WALK: begin
                if (i_stat.at_end || i_stat.k_full) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.mul_op   = r_op;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SQ:   o_cmd.mul_en   = 1'b1;
            ST_SUM:  o_cmd.sum      = 1'b1;
            ST_DIVW: o_cmd.num_load = i_stat.div_done;
            ST_PROD: o_cmd.mul_en   = 1'b1;
            ST_WALK: begin
                o_cmd.step = !i_stat.at_end && !i_stat.k_full && i_stat.out_free;
            end
            ST_FINAL: o_cmd.fin = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

/* rtl/voxel_ray_traversal.sv */
// Top level of the voxel ray traversal block: controller plus datapath.
// Depends on vrt_pkg, vrt_ctrl, vrt_datapath.
//
// One ray is taken per transaction on the slave side; the block then works on
// it alone. Setup runs the bit-serial divider lanes (COORD_BITS iterations) that
// map both end points to voxels, followed by six passes through the shared
// multiplier. The walk then emits one voxel per cycle while the output is not
// stalled: N free voxels, then the surface voxel.
// A ray outside the range window is dropped with no output.
// Configuration writes must be made while the block is idle.
module voxel_ray_traversal #(
    parameter int COORD_BITS      = vrt_pkg::COORD_BITS_DEF,
    parameter int MAX_FREE_VOXELS = vrt_pkg::MAX_FREE_VOXELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vrt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [vrt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // origin_x, origin_y, origin_z, hit_x, hit_y, hit_z, zero pad
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // voxel_x, voxel_y, voxel_z, zero pad
    output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // is_surface, cut_short
    output logic [1:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);
    import vrt_pkg::*;

    localparam int OUT_W = ((3*COORD_BITS+7)/8)*8;

    t_dp_cmd                 cmd;
    t_dp_stat                stat;
    logic [3*COORD_BITS-1:0] vox;
    logic                    surf;
    logic                    cut;

    vrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    vrt_datapath #(
        .COORD_BITS      (COORD_BITS),
        .MAX_FREE_VOXELS (MAX_FREE_VOXELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_coords    (s_axis_tdata[6*COORD_BITS-1:0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_vox       (vox),
        .o_surf      (surf),
        .o_last      (m_axis_tlast),
        .o_cut       (cut)
    );

    assign m_axis_tdata = OUT_W'(vox);
    assign m_axis_tuser = {cut, surf};

endmodule

/* rtl/vrt_checker.sv */
// Port-level checker for voxel_ray_traversal, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module vrt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    `VRT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped while stalled")
    `VRT_ASSERT(a_last_surface, m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[0]), "last and surface disagree")
    `VRT_ASSERT(a_cut_on_last, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast, "cut flag on a free voxel")
    `VRT_ASSERT(a_one_ray, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready held after a ray was taken")

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
